FILE: hdl/bbe_pkg.sv
package bbe_pkg;

  localparam int ROW_W        = 64;
  localparam int IDX_W        = 6;
  localparam int DIM_W        = 7;
  localparam int MAX_SIDE_DEF = 64;
  localparam int Q_DEPTH      = 8;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

  typedef struct packed {
    logic [ROW_W-1:0] bits;
    logic [IDX_W-1:0] idx;
    logic             last;
  } result_t;

  typedef struct packed {
    logic push_a;
    logic push_b;
  } push_ctl_t;

endpackage

FILE: hdl/binary_border_extraction.sv
// A result row reaches the output through the input stage register, then the output
// queue, after the transfer of the input row that completes it.
// Throughput: one row per cycle while in_ready holds (output queue has room); the final
// row of a frame of two or more rows yields two results, absorbed by the 8-entry queue.
// Reset (synchronous, active high): row counter, stored rows and queue cleared,
// dimension set to 64.
module binary_border_extraction #(
  parameter int MAX_SIDE = bbe_pkg::MAX_SIDE_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [bbe_pkg::DIM_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [bbe_pkg::ROW_W-1:0] row_bits,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [bbe_pkg::ROW_W-1:0] out_row_bits,
  output logic [bbe_pkg::IDX_W-1:0] out_row_index,
  output logic                      last
);
  import bbe_pkg::*;

  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  logic [DIM_W-1:0]    dimension;
  logic [DIM_W-1:0]    side;
  logic [MAX_SIDE-1:0] mask;
  logic [MAX_SIDE-1:0] row_in;
  logic                final_row;
  logic                in_fire;

  logic [IDX_W-1:0]    row_count;
  logic [MAX_SIDE-1:0] prior_row;
  logic [MAX_SIDE-1:0] older_row;

  logic                s1_valid;
  logic [MAX_SIDE-1:0] s1_above;
  logic [MAX_SIDE-1:0] s1_mid;
  logic [MAX_SIDE-1:0] s1_below;
  logic [IDX_W-1:0]    s1_cnt;
  logic                s1_has_pre;
  logic                s1_final;
  logic [DIM_W-1:0]    s1_side;

  logic [MAX_SIDE-1:0] filtered;
  push_ctl_t           push;
  result_t             push_a_data;
  result_t             push_b_data;
  result_t             head;
  logic [CNT_W-1:0]    q_count;
  logic [1:0]          s1_n;

  always_comb begin
    if (dimension == '0) begin
      side = DIM_W'(1);
    end else if (dimension > DIM_W'(MAX_SIDE)) begin
      side = DIM_W'(MAX_SIDE);
    end else begin
      side = dimension;
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_SIDE; j++) begin
      mask[j] = DIM_W'(j) < side;
    end
  end

  assign row_in    = row_bits[MAX_SIDE-1:0] & mask;
  assign final_row = ({1'b0, row_count} >= side - DIM_W'(1));
  assign in_fire   = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= DIM_RESET;
    end else if (cfg_wr_en) begin
      dimension <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      prior_row <= '0;
      older_row <= '0;
      s1_valid  <= 1'b0;
    end else begin
      s1_valid <= in_fire;
      if (in_fire) begin
        if (final_row) begin
          row_count <= '0;
          prior_row <= '0;
          older_row <= '0;
        end else begin
          row_count <= row_count + IDX_W'(1);
          prior_row <= row_in;
          older_row <= prior_row;
        end
      end
    end
  end

  // Stored rows are re-masked so a dimension change mid-frame applies at once
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_above   <= older_row & mask;
      s1_mid     <= prior_row & mask;
      s1_below   <= row_in;
      s1_cnt     <= row_count;
      s1_has_pre <= (row_count != '0);
      s1_final   <= final_row;
      s1_side    <= side;
    end
  end

  bbe_border #(
    .MAX_SIDE(MAX_SIDE)
  ) u_border (
    .above   (s1_above),
    .mid     (s1_mid),
    .below   (s1_below),
    .idx     (s1_cnt - IDX_W'(1)),
    .side    (s1_side),
    .filtered(filtered)
  );

  // Predecessor goes first, then the final row with last set
  always_comb begin
    push.push_a = s1_valid & (s1_has_pre | s1_final);
    push.push_b = s1_valid & s1_has_pre & s1_final;
    push_b_data.bits = ROW_W'(s1_below);
    push_b_data.idx  = s1_cnt;
    push_b_data.last = 1'b1;
    if (s1_has_pre) begin
      push_a_data.bits = ROW_W'(filtered);
      push_a_data.idx  = s1_cnt - IDX_W'(1);
      push_a_data.last = 1'b0;
    end else begin
      push_a_data = push_b_data;
    end
  end

  assign s1_n = {1'b0, push.push_a} + {1'b0, push.push_b};

  // Leave room for the item in the stage register and one more that may yield two
  assign in_ready = ({1'b0, q_count} + (CNT_W + 1)'(s1_n) + (CNT_W + 1)'(2))
                    <= (CNT_W + 1)'(Q_DEPTH);

  bbe_out_queue #(
    .DEPTH(Q_DEPTH)
  ) u_out_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_a_data(push_a_data),
    .push_b_data(push_b_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .head       (head),
    .count      (q_count)
  );

  assign out_row_bits  = head.bits;
  assign out_row_index = head.idx;
  assign last          = head.last;

`ifndef ASSERT_OFF
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= CNT_W'(Q_DEPTH))
    else $error("output queue overflow");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    in_fire && final_row |=> row_count == '0)
    else $error("row counter not cleared after final row");

  a_pre_index: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_has_pre |-> s1_cnt != '0)
    else $error("predecessor emitted on first row of frame");
`endif

endmodule

FILE: hdl/bbe_border.sv
module bbe_border #(
  parameter int MAX_SIDE = bbe_pkg::MAX_SIDE_DEF
) (
  input  logic [MAX_SIDE-1:0]       above,
  input  logic [MAX_SIDE-1:0]       mid,
  input  logic [MAX_SIDE-1:0]       below,
  input  logic [bbe_pkg::IDX_W-1:0] idx,
  input  logic [bbe_pkg::DIM_W-1:0] side,
  output logic [MAX_SIDE-1:0]       filtered
);
  import bbe_pkg::*;

  logic [MAX_SIDE-1:0] inner;
  logic [MAX_SIDE-1:0] full;
  logic                active;

  // Interior columns: 1 .. side-2
  always_comb begin
    for (int j = 0; j < MAX_SIDE; j++) begin
      inner[j] = (j != 0) && (DIM_W'(j) < side - DIM_W'(1));
    end
  end

  // Only interior rows of an image of at least three rows are filtered
  assign active = (side >= DIM_W'(3)) && (idx != '0) &&
                  ({1'b0, idx} <= side - DIM_W'(2));

  assign full = (above << 1) & above & (above >> 1)
              & (mid << 1) & (mid >> 1)
              & (below << 1) & below & (below >> 1)
              & inner;

  assign filtered = active ? (mid & ~full) : mid;

endmodule

FILE: hdl/bbe_out_queue.sv
module bbe_out_queue #(
  parameter  int DEPTH = bbe_pkg::Q_DEPTH,
  localparam int CNT_W = $clog2(DEPTH + 1),
  localparam int PTR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  bbe_pkg::push_ctl_t push,
  input  bbe_pkg::result_t  push_a_data,
  input  bbe_pkg::result_t  push_b_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bbe_pkg::result_t  head,
  output logic [CNT_W-1:0]  count
);
  import bbe_pkg::*;

  // DEPTH is a power of two so the pointers wrap on their own
  result_t          q [DEPTH];
  logic [PTR_W-1:0] wr;
  logic [PTR_W-1:0] rd;
  logic [1:0]       n_push;
  logic             pop;

  assign n_push    = {1'b0, push.push_a} + {1'b0, push.push_b};
  assign out_valid = (count != '0);
  assign pop       = out_valid & out_ready;
  assign head      = q[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      wr    <= wr + PTR_W'(n_push);
      rd    <= rd + PTR_W'(pop);
      count <= count + CNT_W'(n_push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.push_a) begin
      q[wr] <= push_a_data;
    end
    if (push.push_b) begin
      q[wr + PTR_W'(1)] <= push_b_data;
    end
  end

endmodule
